// File: design/path_canonicalizer_top_assert.svh
// ----------------------------------------------------------------------------
// Path canonicalizer assertion macros
// Clocked on clk and disabled while rst is high in the including scope.
// ----------------------------------------------------------------------------
`ifndef PATH_CANONICALIZER_TOP_ASSERT_SVH
`define PATH_CANONICALIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PCAN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PCAN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pcan_pkg.sv
// ----------------------------------------------------------------------------
// pcan_pkg
// Shared types and constants of the path canonicalizer.
// ----------------------------------------------------------------------------
package pcan_pkg;

  // Default size of the path buffer in bytes
  localparam int PCAN_PATH_BYTES = 256;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_BASE   = 3'd1,
    OP_PATH   = 3'd2,
    OP_FINISH = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_FILE     = 3'd1,
    ST_DIR      = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_READ     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STRIP,
    S_POST,
    S_RDATA
  } state_t;

  // What to finish once a walk back through the buffer is done
  typedef enum logic [1:0] {
    PK_FIRST,
    PK_SLASH,
    PK_FINISH
  } pend_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic [7:0] length;
  } result_t;

endpackage

// File: design/pcan_ram.sv
// ----------------------------------------------------------------------------
// pcan_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pcan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/pcan_out_reg.sv
// ----------------------------------------------------------------------------
// pcan_out_reg
// Output register stage: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module pcan_out_reg
  import pcan_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [2:0] status,
  output logic [7:0] data_out,
  output logic [7:0] result_length
);

  result_t res_q;

  // Valid flag: set on load, clear on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign status        = res_q.status;
  assign data_out      = res_q.data;
  assign result_length = res_q.length;

endmodule

// File: design/pcan_ctrl.sv
// ----------------------------------------------------------------------------
// pcan_ctrl
// Sequencer: decodes items, updates the path state, drives the buffer RAM
// and walks back through it to strip components.
// ----------------------------------------------------------------------------
module pcan_ctrl
  import pcan_pkg::*;
#(
  parameter int PATH_BYTES = PCAN_PATH_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    operation,
  input  logic [7:0]                    byte_value,
  input  logic [7:0]                    read_index,
  input  logic                          out_valid,
  input  logic                          out_ready,
  output logic                          res_load,
  output result_t                       res,
  output logic                          wr_en,
  output logic [$clog2(PATH_BYTES)-1:0] wr_addr,
  output logic [7:0]                    wr_data,
  output logic [$clog2(PATH_BYTES)-1:0] rd_addr,
  input  logic [7:0]                    rd_data
);

  localparam int AW = $clog2(PATH_BYTES);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] PB_P  = PW'(PATH_BYTES);
  localparam logic [PW:0]   PB_W  = (PW+1)'(PATH_BYTES);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  state_t      state, state_next;
  pend_t       kind, kind_next;
  logic        adj, adj_next;
  logic [7:0]  pbyte, pbyte_next;
  logic        rd_ok, rd_ok_next;

  logic [PW-1:0] wp, wp_next;
  logic [PW-1:0] cs, cs_next;
  logic [PW-1:0] cl, cl_next;
  logic [PW-1:0] ic, ic_next;
  logic          dir, dir_next;
  logic          sym, sym_next;
  logic          ovf, ovf_next;
  logic          dots, dots_next;

  logic          accept;
  logic          wp_gt1;
  logic [PW-1:0] wp_dec, wp1, ic_inc, cs_v, wp_f, cs_f;
  logic [PW:0]   csum, apos;
  logic          c_ovf, c_skip, c_dotdot, dir_v, dir_f;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Shared position arithmetic
  assign wp_gt1   = wp > ONE_P;
  assign wp_dec   = wp - ONE_P;
  assign wp1      = wp_gt1 ? wp + ONE_P : wp;
  assign csum     = {1'b0, wp1} + {1'b0, cl};
  assign c_ovf    = csum >= PB_W;
  assign c_skip   = (cl == '0) || (dots && cl == ONE_P);
  assign c_dotdot = dots && (cl == PW'(2));
  assign ic_inc   = (ic < PB_P) ? ic + ONE_P : ic;
  assign dir_v    = (ic == '0) ? (wp == ONE_P) : dir;
  assign cs_v     = (cl == '0) ? wp + PW'(wp_gt1) : cs;
  assign apos     = {1'b0, cs_v} + {1'b0, cl};

  // Position after a walk back: drop the slash before the removed component
  assign wp_f = (adj && wp_gt1) ? wp_dec : wp;
  assign dir_f = adj ? !wp_gt1 : dir;
  assign cs_f = wp_f + PW'(wp_f > ONE_P);

  // State and path registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= PK_FIRST;
      adj   <= 1'b0;
      rd_ok <= 1'b0;
      wp    <= '0;
      cs    <= '0;
      cl    <= '0;
      ic    <= '0;
      dir   <= 1'b0;
      sym   <= 1'b0;
      ovf   <= 1'b0;
      dots  <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      adj   <= adj_next;
      rd_ok <= rd_ok_next;
      wp    <= wp_next;
      cs    <= cs_next;
      cl    <= cl_next;
      ic    <= ic_next;
      dir   <= dir_next;
      sym   <= sym_next;
      ovf   <= ovf_next;
      dots  <= dots_next;
    end
  end

  // Held byte for a deferred first path byte
  always_ff @(posedge clk) begin
    pbyte <= pbyte_next;
  end

  // Next state, RAM access and results
  always_comb begin
    state_next = state;
    kind_next  = kind;
    adj_next   = adj;
    pbyte_next = pbyte;
    rd_ok_next = rd_ok;
    wp_next    = wp;
    cs_next    = cs;
    cl_next    = cl;
    ic_next    = ic;
    dir_next   = dir;
    sym_next   = sym;
    ovf_next   = ovf;
    dots_next  = dots;
    wr_en      = 1'b0;
    wr_addr    = wp[AW-1:0];
    wr_data    = 8'd0;
    rd_addr    = wp_dec[AW-1:0];
    res_load   = 1'b0;
    res        = '{status: ST_ACCEPTED, data: 8'd0, length: 8'd0};

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (op_t'(operation))
            OP_START: begin
              wp_next   = '0;
              cs_next   = '0;
              cl_next   = '0;
              ic_next   = '0;
              dir_next  = 1'b0;
              ovf_next  = 1'b0;
              dots_next = 1'b0;
              sym_next  = byte_value[0];
            end
            OP_BASE: begin
              // Load base bytes until the first path byte
              if (ic == '0 && byte_value != 8'd0 && wp < PB_P) begin
                wr_en   = 1'b1;
                wr_data = byte_value;
                wp_next = wp + ONE_P;
              end
            end
            OP_PATH: begin
              if (!ovf && byte_value != 8'd0) begin
                if (ic == '0 && byte_value == SLASH_CHAR) begin
                  // Absolute path: restart at the root
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = SLASH_CHAR;
                  wp_next  = ONE_P;
                  dir_next = 1'b1;
                  ic_next  = ONE_P;
                end else if (ic == '0 && sym && wp_gt1) begin
                  // Symlink: walk back to the parent of the base first
                  res_load   = 1'b0;
                  pbyte_next = byte_value;
                  kind_next  = PK_FIRST;
                  adj_next   = 1'b1;
                  state_next = S_STRIP;
                end else if (ic == '0 && !sym && (wp + ONE_P) >= PB_P) begin
                  ovf_next = 1'b1;
                  dir_next = dir_v;
                  ic_next  = ic_inc;
                end else begin
                  ic_next = ic_inc;
                  if (ic_inc >= PB_P) begin
                    ovf_next = 1'b1;
                    dir_next = dir_v;
                  end else if (byte_value == SLASH_CHAR) begin
                    // Close the pending component
                    cl_next  = '0;
                    dir_next = 1'b1;
                    if (c_skip) begin
                      dir_next = 1'b1;
                    end else if (c_dotdot) begin
                      if (wp_gt1) begin
                        res_load   = 1'b0;
                        kind_next  = PK_SLASH;
                        adj_next   = 1'b1;
                        state_next = S_STRIP;
                      end
                    end else begin
                      if (wp_gt1 && wp < PB_P) begin
                        wr_en   = 1'b1;
                        wr_data = SLASH_CHAR;
                      end
                      if (c_ovf) begin
                        ovf_next = 1'b1;
                        wp_next  = wp1;
                      end else begin
                        wp_next = csum[PW-1:0];
                      end
                    end
                  end else begin
                    // Append to the pending component
                    cs_next   = cs_v;
                    dots_next = ((cl == '0) || dots) && (byte_value == DOT_CHAR);
                    cl_next   = (cl < PB_P) ? cl + ONE_P : cl;
                    dir_next  = dir_v;
                    if (apos < PB_W) begin
                      wr_en   = 1'b1;
                      wr_addr = apos[AW-1:0];
                      wr_data = byte_value;
                    end
                  end
                end
              end
            end
            OP_FINISH: begin
              if (ic == '0) begin
                res.status = ST_EMPTY;
              end else if (ovf) begin
                res.status = ST_TOO_LONG;
              end else begin
                // Commit the pending component, terminate in S_POST (after S_STRIP for "..")
                res_load   = 1'b0;
                cl_next    = '0;
                kind_next  = PK_FINISH;
                adj_next   = 1'b0;
                state_next = S_POST;
                if (c_skip) begin
                  dir_next = dir;
                end else if (c_dotdot) begin
                  if (wp_gt1) begin
                    adj_next   = 1'b1;
                    state_next = S_STRIP;
                  end else begin
                    dir_next = 1'b1;
                  end
                end else begin
                  if (wp_gt1 && wp < PB_P) begin
                    wr_en   = 1'b1;
                    wr_data = SLASH_CHAR;
                  end
                  if (c_ovf) begin
                    ovf_next = 1'b1;
                    wp_next  = wp1;
                  end else begin
                    wp_next  = csum[PW-1:0];
                    dir_next = 1'b0;
                  end
                end
              end
            end
            OP_READ: begin
              res_load   = 1'b0;
              rd_addr    = AW'(read_index);
              rd_ok_next = 32'(read_index) < 32'(PATH_BYTES);
              state_next = S_RDATA;
            end
            default: begin
              res.status = ST_ACCEPTED;
            end
          endcase
        end
      end

      S_STRIP: begin
        // Step back one byte per cycle until a slash or the root
        if (rd_data == SLASH_CHAR) begin
          state_next = S_POST;
        end else begin
          wp_next = wp_dec;
          rd_addr = AW'(wp_dec - ONE_P);
          if (wp_dec <= ONE_P) begin
            state_next = S_POST;
          end
        end
      end

      S_POST: begin
        res_load   = 1'b1;
        state_next = S_IDLE;
        case (kind)
          PK_FIRST: begin
            // Deferred first byte of a relative symlink path
            wp_next   = wp_f;
            dir_next  = (wp_f == ONE_P);
            ic_next   = ONE_P;
            cs_next   = cs_f;
            cl_next   = ONE_P;
            dots_next = (pbyte == DOT_CHAR);
            if (cs_f < PB_P) begin
              wr_en   = 1'b1;
              wr_addr = cs_f[AW-1:0];
              wr_data = pbyte;
            end
          end
          PK_SLASH: begin
            wp_next  = wp_f;
            dir_next = 1'b1;
          end
          PK_FINISH: begin
            wp_next  = wp_f;
            dir_next = dir_f;
            if (ovf) begin
              res.status = ST_TOO_LONG;
            end else begin
              if (wp_f < PB_P) begin
                wr_en   = 1'b1;
                wr_addr = wp_f[AW-1:0];
                wr_data = 8'd0;
              end
              res.status = dir_f ? ST_DIR : ST_FILE;
              res.length = 8'(wp_f);
            end
          end
          default: begin
            res.status = ST_ACCEPTED;
          end
        endcase
      end

      S_RDATA: begin
        res_load   = 1'b1;
        res.status = ST_READ;
        res.data   = rd_ok ? rd_data : 8'd0;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/path_canonicalizer_top.sv
// ----------------------------------------------------------------------------
// path_canonicalizer_top
// Builds an absolute canonical path in a byte buffer from base and path
// bytes, reports file, directory or error on finish, and reads back bytes.
//
//   channel | signals                                      | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid in_ready operation byte_value        | consumer
//           | read_index                                   |
//   out     | out_valid out_ready status data_out           | producer
//           | result_length                                |
//
// Start, base byte, path byte, unused codes and a finish that reports an
// empty or too-long path load their result when accepted (bar the walks
// below); a read passes through S_RDATA (buffer read latency), any other
// finish through S_POST (terminator write). A ".." component, or the
// first relative byte in symlink mode, walks back through the buffer RAM
// one byte per cycle and takes no new item until done. An item enters
// only while the output register is empty or being taken. Reset is
// synchronous and clears the control state; the buffer is not cleared.
// ----------------------------------------------------------------------------
module path_canonicalizer_top
  import pcan_pkg::*;
#(
  parameter int PATH_BYTES = PCAN_PATH_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] operation,
  input  logic [7:0] byte_value,
  input  logic [7:0] read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [7:0] data_out,
  output logic [7:0] result_length
);

  localparam int AW = $clog2(PATH_BYTES);

  logic          res_load;
  result_t       res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Sequencer
  pcan_ctrl #(
    .PATH_BYTES(PATH_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .byte_value (byte_value),
    .read_index (read_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_load   (res_load),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // Path buffer
  pcan_ram #(
    .WIDTH(8),
    .DEPTH(PATH_BYTES)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register
  pcan_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (res_load),
    .res           (res),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .data_out      (data_out),
    .result_length (result_length)
  );

endmodule

// File: design/pcan_checker.sv
// ----------------------------------------------------------------------------
// pcan_checker
// Port-level checks on the path canonicalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "path_canonicalizer_top_assert.svh"

module pcan_checker
  import pcan_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] data_out,
  input logic [7:0] result_length
);

  // Hold a stalled result
  `PCAN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(data_out) && $stable(result_length), "stalled result changed")

  // Single result slot: no transfer in while a result is stuck
  `PCAN_ASSERT_NOW(a_no_accept_full, out_valid && !out_ready, !in_ready, "input taken while output full")

  // Data only on read results
  `PCAN_ASSERT_NOW(a_data_zero, out_valid && status != ST_READ, data_out == 8'd0, "data on non-read result")

  // Length only on done results
  `PCAN_ASSERT_NOW(a_len_zero, out_valid && status != ST_FILE && status != ST_DIR, result_length == 8'd0, "length on non-done result")

  // Drop output after reset
  `PCAN_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "output valid after reset")

endmodule

bind path_canonicalizer_top pcan_checker u_pcan_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .data_out      (data_out),
  .result_length (result_length)
);
